### hdl/rhcb_pkg.sv
// Package for the rolling hash chunk boundary block.
// Constants, register indexes, controller state and command types. No dependencies.
package rhcb_pkg;

    localparam int MaxWindow   = 64;
    localparam int MinWindow   = 4;
    localparam int SlotW       = $clog2(MaxWindow);
    localparam int CntW        = $clog2(MaxWindow + 1);
    localparam int HashW       = 31;
    localparam int WinCfgW     = 7;
    localparam int CfgIdxW     = 2;
    localparam int CfgDataW    = 31;
    localparam logic [HashW-1:0] KrPrime = 31'd1999999973;
    localparam logic [HashW-1:0] KrBase  = 31'd256;
    localparam logic [HashW-1:0] WeightReset = 31'd1593593066;

    localparam logic [CfgIdxW-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_MODULUS     = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ALLOW_ALL   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WMUL,
        ST_WRED,
        ST_MUL,
        ST_RED,
        ST_FOLD,
        ST_DIV,
        ST_OUT
    } rhcb_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch byte, read oldest slot
        logic mul_start;  // start a modular multiply
        logic mul_sel_w;  // 1 = weight recompute multiply
        logic fold;       // take hash minus leaving byte
        logic fold_step;  // shift one bit of the new byte in
        logic div_start;  // start modulus check
        logic wt_step;    // take weight multiply result
        logic wt_init;    // begin weight recompute
        logic out_load;   // present result
    } rhcb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mul_done;
        logic fold_last;
        logic div_done;
        logic wt_more;
    } rhcb_sts_t;

endpackage

### hdl/rhcb_modmul.sv
// Modular multiplier a*b mod prime, one bit of b per cycle (shift and add).
// Depends on rhcb_pkg.
module rhcb_modmul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rhcb_pkg::HashW-1:0] a,
    input  logic [rhcb_pkg::HashW-1:0] b,
    output logic                      done,
    output logic [rhcb_pkg::HashW-1:0] product
);
    import rhcb_pkg::*;

    logic [HashW-1:0] acc_reg, acc_next;
    logic [HashW-1:0] b_reg, b_next;
    logic [HashW-1:0] a_reg;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [HashW:0]   dbl, dbl_r, sum;
    logic [HashW-1:0] acc2;

    // acc = 2*acc (+ a) mod prime, msb of b first
    always_comb begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, KrPrime}) ? dbl - {1'b0, KrPrime} : dbl;
        sum   = dbl_r + (b_reg[HashW-1] ? {1'b0, a_reg} : '0);
        acc2  = (sum >= {1'b0, KrPrime}) ? HashW'(sum - {1'b0, KrPrime}) : sum[HashW-1:0];
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            acc_next  = '0;
            b_next    = b;
            cnt_next  = 5'(HashW - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc2;
            b_next   = {b_reg[HashW-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        acc_reg <= acc_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
        if (start) a_reg <= a;
    end

    assign done    = busy_reg && (cnt_reg == 5'd0);
    assign product = acc2;
endmodule

### hdl/rhcb_moddiv.sv
// Divisibility check: restoring remainder of hash by modulus, one bit per cycle.
// Depends on rhcb_pkg.
module rhcb_moddiv (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rhcb_pkg::HashW-1:0] dividend,
    input  logic [rhcb_pkg::HashW-1:0] divisor,
    output logic                      done,
    output logic                      is_zero
);
    import rhcb_pkg::*;

    logic [HashW:0]   rem_reg, rem_next;
    logic [HashW-1:0] num_reg, num_next;
    logic [HashW-1:0] dvs_reg;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             fin_reg, fin_next;
    logic             zero_reg, zero_next;
    logic [HashW:0]   sh, rem2;

    always_comb begin
        sh   = {rem_reg[HashW-1:0], num_reg[HashW-1]};
        rem2 = (sh >= {1'b0, dvs_reg}) ? sh - {1'b0, dvs_reg} : sh;
        rem_next  = rem_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fin_next  = fin_reg;
        zero_next = zero_reg;
        if (start) begin
            rem_next  = '0;
            num_next  = dividend;
            cnt_next  = 5'(HashW - 1);
            busy_next = 1'b1;
            fin_next  = 1'b0;
        end else if (busy_reg) begin
            rem_next = rem2;
            num_next = {num_reg[HashW-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
                zero_next = (rem2 == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
        if (start) dvs_reg <= divisor;
    end

    // divisor zero: remainder is the hash itself; result held until next start
    assign done    = fin_reg;
    assign is_zero = zero_reg;
endmodule

### hdl/rhcb_datapath.sv
// Datapath: window memory, hash, weight, multiplier and divisibility check.
// Depends on rhcb_pkg, rhcb_modmul, rhcb_moddiv.
module rhcb_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rhcb_pkg::rhcb_cmd_t          cmd,
    output rhcb_pkg::rhcb_sts_t          sts,
    input  logic [7:0]                   s_data_byte,
    input  logic                         cfg_wr_en,
    input  logic [rhcb_pkg::CfgIdxW-1:0] cfg_wr_index,
    input  logic [rhcb_pkg::CfgDataW-1:0] cfg_wr_data,
    output logic [rhcb_pkg::HashW-1:0]   m_window_hash,
    output logic                         m_boundary,
    output logic                         m_invalid_symbol
);
    import rhcb_pkg::*;

    logic [7:0]       win_mem [MaxWindow];
    logic [MaxWindow-1:0] vld_reg;
    logic [7:0]       old_reg;
    logic [7:0]       byte_reg;
    logic [SlotW-1:0] slot_reg;
    logic [SlotW-1:0] cur_slot;
    logic [CntW-1:0]  size_reg;
    logic [HashW-1:0] hash_reg, weight_reg, wacc_reg, modulus_reg;
    logic             allow_reg;
    logic [CntW-1:0]  wcnt_reg;
    logic [HashW-1:0] mul_a, mul_b, prod;
    logic             mul_done, div_done, div_zero;
    logic [HashW:0]   h1;
    logic [HashW-1:0] h1r;
    logic [2:0]       fcnt_reg;
    logic             fbit;
    logic [HashW:0]   fsum;
    logic [HashW-1:0] fred;
    logic [CntW-1:0]  eff;
    logic [WinCfgW-1:0] wsz;

    // clamp of written window size
    always_comb begin
        wsz = cfg_wr_data[WinCfgW-1:0];
        if (wsz < WinCfgW'(MinWindow))      eff = CntW'(MinWindow);
        else if (wsz > WinCfgW'(MaxWindow)) eff = CntW'(MaxWindow);
        else                                eff = CntW'(wsz);
    end

    assign cur_slot = (CntW'(slot_reg) >= size_reg) ? '0 : slot_reg;

    assign mul_a = cmd.mul_sel_w ? wacc_reg : weight_reg;
    assign mul_b = cmd.mul_sel_w ? KrBase : {23'd0, old_reg};

    rhcb_modmul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .product(prod)
    );

    // hash - old*weight, reduced
    always_comb begin
        h1  = {1'b0, hash_reg} + {1'b0, KrPrime} - {1'b0, prod};
        h1r = (h1 >= {1'b0, KrPrime}) ? HashW'(h1 - {1'b0, KrPrime}) : h1[HashW-1:0];
    end

    // new byte shifted in msb first: h = 2h + bit mod prime, eight steps
    always_comb begin
        fbit = byte_reg[3'd7 - fcnt_reg];
        fsum = {hash_reg, 1'b0} + {{HashW{1'b0}}, fbit};
        fred = (fsum >= {1'b0, KrPrime}) ? HashW'(fsum - {1'b0, KrPrime}) : fsum[HashW-1:0];
    end

    rhcb_moddiv u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(hash_reg), .divisor(modulus_reg),
        .done(div_done), .is_zero(div_zero)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            slot_reg    <= '0;
            hash_reg    <= '0;
            size_reg    <= CntW'(10);
            weight_reg  <= WeightReset;
            modulus_reg <= 31'd100;
            allow_reg   <= 1'b0;
            wcnt_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_WINDOW_SIZE: begin
                        size_reg <= eff;
                        wcnt_reg <= eff - CntW'(1);
                        if (CntW'(slot_reg) >= eff) slot_reg <= '0;
                    end
                    REG_MODULUS:   modulus_reg <= cfg_wr_data;
                    REG_ALLOW_ALL: allow_reg <= cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (cmd.wt_init) wacc_reg <= 31'd1;
            if (cmd.wt_step) begin
                wacc_reg <= prod;
                wcnt_reg <= wcnt_reg - CntW'(1);
                if (wcnt_reg == CntW'(1)) weight_reg <= prod;
            end
            if (cmd.wt_init && wcnt_reg == '0) weight_reg <= 31'd1;
            if (cmd.load) begin
                byte_reg <= s_data_byte;
                old_reg  <= vld_reg[cur_slot] ? win_mem[cur_slot] : 8'd0;
                vld_reg[cur_slot] <= 1'b1;
                slot_reg <= (CntW'(cur_slot) + CntW'(1) >= size_reg) ? '0 : cur_slot + 1'b1;
            end
            if (cmd.fold) begin
                hash_reg <= h1r;
                fcnt_reg <= '0;
            end
            if (cmd.fold_step) begin
                hash_reg <= fred;
                fcnt_reg <= fcnt_reg + 3'd1;
            end
            if (cmd.out_load) begin
                m_window_hash    <= hash_reg;
                m_boundary       <= (modulus_reg == '0) ? (hash_reg == '0) : div_zero;
                m_invalid_symbol <= !allow_reg && (byte_reg <= 8'd2);
            end
        end
    end

    // window store write
    always_ff @(posedge aclk) begin
        if (cmd.load) win_mem[cur_slot] <= s_data_byte;
    end

    assign sts.mul_done  = mul_done;
    assign sts.fold_last = (fcnt_reg == 3'd7);
    assign sts.div_done  = div_done;
    assign sts.wt_more   = (wcnt_reg != '0);
endmodule

### hdl/rhcb_ctrl.sv
// Controller state machine: sequences weight recompute, hash update, check, output.
// Depends on rhcb_pkg.
module rhcb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  wt_req,
    output rhcb_pkg::rhcb_cmd_t   cmd,
    input  rhcb_pkg::rhcb_sts_t   sts
);
    import rhcb_pkg::*;

    rhcb_state_t state_reg, state_next;
    logic        mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        mv_next    = mv_reg && !m_ready;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (wt_req) begin
                    cmd.wt_init = 1'b1;
                    state_next  = ST_WMUL;
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd.load   = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_WMUL: begin
                if (sts.wt_more) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel_w = 1'b1;
                    state_next    = ST_WRED;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRED: begin
                cmd.mul_sel_w = 1'b1;
                if (sts.mul_done) begin
                    cmd.wt_step = 1'b1;
                    state_next  = ST_WMUL;
                end
            end
            ST_MUL: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_RED;
            end
            ST_RED: begin
                if (sts.mul_done) begin
                    cmd.fold   = 1'b1;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold_step = 1'b1;
                if (sts.fold_last) state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (sts.div_done && (!mv_reg || m_ready)) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = mv_reg;
endmodule

### hdl/rolling_hash_chunk_boundary.sv
// Top level of the rolling hash chunk boundary block.
// Depends on rhcb_pkg, rhcb_ctrl, rhcb_datapath.
//
// One byte per input beat (s_valid/s_ready, s_data_byte); one result beat per
// byte (m_valid/m_ready: m_window_hash, m_boundary, m_invalid_symbol).
// The hash keeps a Karp-Rabin sum of the last window_size bytes mod 1999999973.
// Before m_valid rises, each input beat runs a 31-step shift-and-add modular
// multiply for the leaving byte, an 8-step shift of the new byte into the hash,
// then a 31-step restoring remainder for the boundary check against the
// modulus. Bytes are handled one at a time. Writing window_size recomputes
// 256^(w-1) by w-1 serial multiplies before the next byte is taken.
// The result register frees the datapath: a new byte is accepted while the
// previous result still waits; a byte finishing while the receiver stalls
// holds in the output step until the register frees.
// Reset (aresetn low, synchronous) clears the window, hash and registers
// to their defaults: window 10, modulus 100, bytes 0..2 flagged.
module rolling_hash_chunk_boundary (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rhcb_pkg::HashW-1:0]    m_window_hash,
    output logic                          m_boundary,
    output logic                          m_invalid_symbol,
    input  logic                          cfg_wr_en,
    input  logic [rhcb_pkg::CfgIdxW-1:0]  cfg_wr_index,
    input  logic [rhcb_pkg::CfgDataW-1:0] cfg_wr_data
);
    import rhcb_pkg::*;

    rhcb_cmd_t cmd;
    rhcb_sts_t sts;
    logic      wt_req_reg;

    // pending weight recompute after a window size write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wt_req_reg <= 1'b0;
        end else if (cfg_wr_en && cfg_wr_index == REG_WINDOW_SIZE) begin
            wt_req_reg <= 1'b1;
        end else if (cmd.wt_init) begin
            wt_req_reg <= 1'b0;
        end
    end

    rhcb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .wt_req(wt_req_reg), .cmd(cmd), .sts(sts)
    );

    rhcb_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_data_byte(s_data_byte),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .m_window_hash(m_window_hash), .m_boundary(m_boundary),
        .m_invalid_symbol(m_invalid_symbol)
    );
endmodule

### dv/rolling_hash_chunk_boundary_tb.sv
// Testbench for rolling_hash_chunk_boundary: directed and random byte streams,
// checked against an in-bench rolling hash predictor. Depends on rhcb_pkg and the RTL.
module rolling_hash_chunk_boundary_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rhcb_pkg::*;

    localparam longint unsigned Prime = 64'd1999999973;
    localparam int IdleLimit = 20000;
    localparam int Settle = 100;
    localparam logic [CfgIdxW-1:0] RegUnknown = 2'd3;

    typedef struct {
        logic [HashW-1:0] hash;
        logic             boundary;
        logic             invalid;
    } hash_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_data_byte = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [HashW-1:0] m_window_hash;
    logic m_boundary;
    logic m_invalid_symbol;
    logic cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0] cfg_wr_index = '0;
    logic [CfgDataW-1:0] cfg_wr_data = '0;

    rolling_hash_chunk_boundary dut (.*);

    // predictor state
    logic [7:0]       win_mem [MaxWindow];
    int unsigned      win_slot;
    logic [HashW-1:0] win_hash;
    logic [HashW-1:0] lead_weight;
    logic [6:0]       cfg_window;
    logic [30:0]      cfg_modulus;
    logic             cfg_allow;

    hash_result_t pending_hashes[$];
    int unsigned  mismatches = 0;
    int unsigned  results_seen = 0;
    int unsigned  bytes_sent = 0;
    int unsigned  boundaries_seen = 0;
    int unsigned  idle_pct = 0;
    int unsigned  stall_pct = 0;
    int unsigned  quiet_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned eff_window();
        int unsigned s;
        s = cfg_window;
        if (s < MinWindow) s = MinWindow;
        if (s > MaxWindow) s = MaxWindow;
        return s;
    endfunction

    // 256^(w-1) mod prime for the clamped window
    function automatic void refresh_weight();
        longint unsigned acc;
        longint unsigned b;
        int unsigned e;
        acc = 1;
        b = 256;
        e = eff_window() - 1;
        while (e != 0) begin
            if (e[0]) acc = (acc * b) % Prime;
            b = (b * b) % Prime;
            e = e >> 1;
        end
        lead_weight = acc[HashW-1:0];
        if (win_slot >= eff_window()) win_slot = 0;
    endfunction

    function automatic void predictor_reset();
        foreach (win_mem[i]) win_mem[i] = '0;
        win_slot = 0;
        win_hash = '0;
        cfg_window = 7'd10;
        cfg_modulus = 31'd100;
        cfg_allow = 1'b0;
        refresh_weight();
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        longint unsigned h;
        int unsigned s;
        hash_result_t r;
        s = eff_window();
        if (win_slot >= s) win_slot = 0;
        h = longint'(win_hash) + Prime
            - (longint'(win_mem[win_slot]) * longint'(lead_weight)) % Prime;
        h = (256 * h + b) % Prime;
        win_hash = h[HashW-1:0];
        win_mem[win_slot] = b;
        win_slot = (win_slot + 1 >= s) ? 0 : win_slot + 1;
        r.hash = win_hash;
        if (cfg_modulus == 0) r.boundary = (win_hash == 0);
        else r.boundary = ((win_hash % cfg_modulus) == 0);
        r.invalid = !cfg_allow && (b <= 8'd2);
        pending_hashes = {pending_hashes, r};
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
        mismatches++;
    endtask

    // result checker
    always @(posedge aclk) begin
        hash_result_t r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hashes.size() == 0) begin
                report_mismatch("unexpected beat", m_window_hash, -1);
            end else begin
                r = pending_hashes.pop_front();
                if (m_window_hash !== r.hash) report_mismatch("window_hash", m_window_hash, r.hash);
                if (m_boundary !== r.boundary) report_mismatch("boundary", m_boundary, r.boundary);
                if (m_invalid_symbol !== r.invalid)
                    report_mismatch("invalid_symbol", m_invalid_symbol, r.invalid);
                if (r.boundary) boundaries_seen++;
            end
            results_seen++;
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    // watchdog on beats in either direction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IdleLimit) begin
            $display("Watchdog: no beat for %0d cycles", IdleLimit);
            $display("Mismatches found");
            $finish;
        end
    end

    // one input beat; called and returns at a falling edge
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data_byte = b;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_hashes.size() != 0) @(negedge aclk);
        repeat (Settle) @(negedge aclk);
    endtask

    // register write; block must be idle
    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_WINDOW_SIZE: begin
                cfg_window = data[6:0];
                refresh_weight();
                // weight recompute holds off the next byte
                repeat (4) @(negedge aclk);
                while (!s_ready) @(negedge aclk);
            end
            REG_MODULUS: cfg_modulus = data;
            REG_ALLOW_ALL: cfg_allow = data[0];
            default: ;
        endcase
    endtask

    function automatic logic [7:0] rand_byte();
        int unsigned k;
        k = $urandom_range(9);
        if (k == 0) return 8'($urandom_range(2));
        if (k == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic test_directed();
        // defaults after reset: edge bytes, flagged low symbols
        send_byte(8'd0); send_byte(8'd1); send_byte(8'd2); send_byte(8'd3);
        send_byte(8'd255); send_byte(8'd128);
        wait_drained();
        cfg_write(REG_ALLOW_ALL, 31'd1);
        send_byte(8'd0); send_byte(8'd2); send_byte(8'd255);
        wait_drained();
        // modulus zero: boundary only on a zero hash
        cfg_write(REG_MODULUS, 31'd0);
        cfg_write(REG_WINDOW_SIZE, 31'd4);
        repeat (5) send_byte(8'd0);
        send_byte(8'd7);
        wait_drained();
        // window below minimum, then above maximum with stray upper bits
        cfg_write(REG_WINDOW_SIZE, 31'd0);
        cfg_write(REG_MODULUS, 31'd1);
        repeat (3) send_byte(8'd255);
        wait_drained();
        cfg_write(REG_WINDOW_SIZE, 31'h7FFF_FFFF);
        cfg_write(REG_MODULUS, 31'h7FFF_FFFF);
        cfg_write(REG_ALLOW_ALL, 31'h7FFF_FFFE);
        // unknown index must be ignored
        cfg_write(RegUnknown, 31'h5555_5555);
        repeat (4) send_byte(rand_byte());
        wait_drained();
    endtask

    task automatic test_random(int unsigned n_items, int unsigned idle, int unsigned stall);
        int unsigned done;
        int unsigned chunk;
        int unsigned k;
        idle_pct = idle;
        stall_pct = stall;
        done = 0;
        while (done < n_items) begin
            wait_drained();
            k = $urandom_range(9);
            if (k < 6) cfg_write(REG_WINDOW_SIZE, 31'($urandom_range(12, 4)));
            else if (k < 8) cfg_write(REG_WINDOW_SIZE, 31'($urandom_range(127)));
            else if (k == 8) cfg_write(REG_WINDOW_SIZE, 31'(MaxWindow));
            k = $urandom_range(9);
            if (k < 6) cfg_write(REG_MODULUS, 31'($urandom_range(40, 1)));
            else if (k == 6) cfg_write(REG_MODULUS, 31'd0);
            else cfg_write(REG_MODULUS, 31'($urandom));
            cfg_write(REG_ALLOW_ALL, 31'($urandom));
            chunk = $urandom_range(60, 20);
            repeat (chunk) send_byte(rand_byte());
            done += chunk;
        end
    endtask

    // sender holds off until the block has emptied, then resumes
    task automatic test_drain_pause();
        idle_pct = 0;
        stall_pct = 50;
        repeat (8) send_byte(rand_byte());
        s_valid = 1'b0;
        while (pending_hashes.size() != 0) @(negedge aclk);
        repeat (8) send_byte(rand_byte());
    endtask

    initial begin
        predictor_reset();
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(330, 29, 84);
        test_drain_pause();
        test_random(330, 84, 29);
        test_random(340, 0, 0);
        wait_drained();
        $display("Sent %0d bytes, checked %0d results, %0d of them boundaries,",
                 bytes_sent, results_seen, boundaries_seen);
        $display("over many window, modulus and symbol-mode settings.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
